// ===== rtl/rbt_pkg.sv =====
`timescale 1ns / 1ps

package rbt_pkg;

  localparam int CH_W       = 5;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = CH_W * NUM_CH;
  localparam int LEVEL_W    = 5;
  localparam int TONE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CH_W-1:0]    CH_MAX     = 5'd31;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 5'd16;
  localparam logic [7:0]         LUMA_R     = 8'd76;
  localparam logic [7:0]         LUMA_G     = 8'd151;
  localparam logic [7:0]         LUMA_B     = 8'd29;
  localparam logic [TONE_W-1:0]  TONE_UNITY = 11'd256;

  localparam logic OP_BLEND = 1'b0;
  localparam logic OP_TINT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_TONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_TONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_TONE   = 3'd4;

  typedef struct packed {
    logic [COLOR_W-1:0] blend_color;
    logic [LEVEL_W-1:0] blend_level;
    logic [TONE_W-1:0]  red_tone;
    logic [TONE_W-1:0]  green_tone;
    logic [TONE_W-1:0]  blue_tone;
  } cfg_t;

endpackage

// ===== rtl/rbt_in_if.sv =====
`timescale 1ns / 1ps

interface rbt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] color_in;
  logic        last_in;

  modport source (output valid, output op, output color_in, output last_in, input ready);
  modport sink (input valid, input op, input color_in, input last_in, output ready);
endinterface

// ===== rtl/rbt_out_if.sv =====
`timescale 1ns / 1ps

interface rbt_out_if;
  logic                         valid;
  logic                         ready;
  logic [rbt_pkg::COLOR_W-1:0] color_out;
  logic                         last_out;

  modport source (output valid, output color_out, output last_out, input ready);
  modport sink (input valid, input color_out, input last_out, output ready);
endinterface

// ===== rtl/rbt_cfg_regs.sv =====
`timescale 1ns / 1ps

module rbt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rbt_pkg::cfg_t                   cfg
);

  rbt_pkg::cfg_t cfg_r;
  rbt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rbt_pkg::REG_BLEND_COLOR: cfg_nxt.blend_color = cfg_wdata;
        rbt_pkg::REG_BLEND_LEVEL: cfg_nxt.blend_level = cfg_wdata[rbt_pkg::LEVEL_W-1:0];
        rbt_pkg::REG_RED_TONE:    cfg_nxt.red_tone    = cfg_wdata[rbt_pkg::TONE_W-1:0];
        rbt_pkg::REG_GREEN_TONE:  cfg_nxt.green_tone  = cfg_wdata[rbt_pkg::TONE_W-1:0];
        rbt_pkg::REG_BLUE_TONE:   cfg_nxt.blue_tone   = cfg_wdata[rbt_pkg::TONE_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_color <= '0;
      cfg_r.blend_level <= '0;
      cfg_r.red_tone    <= rbt_pkg::TONE_UNITY;
      cfg_r.green_tone  <= rbt_pkg::TONE_UNITY;
      cfg_r.blue_tone   <= rbt_pkg::TONE_UNITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/rgb555_blend_and_tint_unit.sv =====
`timescale 1ns / 1ps
// The datapath is a four-stage register pipeline from input accept to result valid.
// Throughput: one item per cycle; each stage holds while the stage after it is full and stalled.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// blend colour 0, blend level 0, all tones 256.

module rgb555_blend_and_tint_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  rbt_in_if.sink                          in_ch,
  rbt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = rbt_pkg::CH_W;
  localparam int NC = rbt_pkg::NUM_CH;

  rbt_pkg::cfg_t cfg;

  rbt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage valids and per-stage ready
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: unpack, blend products, luma partial products
  logic [rbt_pkg::LEVEL_W-1:0] level_sat;
  logic [CW-1:0]               src      [NC];
  logic [CW-1:0]               tgt      [NC];
  logic signed [CW:0]          diff     [NC];
  logic signed [11:0]          bprod    [NC];
  logic [11:0]                 luma_r_p;
  logic [12:0]                 luma_g_p;
  logic [9:0]                  luma_b_p;

  always_comb begin
    level_sat = (cfg.blend_level > rbt_pkg::FULL_LEVEL) ? rbt_pkg::FULL_LEVEL
                                                          : cfg.blend_level;
    for (int i = 0; i < NC; i++) begin
      src[i]   = in_ch.color_in[i*CW +: CW];
      tgt[i]   = cfg.blend_color[i*CW +: CW];
      diff[i]  = $signed({1'b0, tgt[i]}) - $signed({1'b0, src[i]});
      bprod[i] = diff[i] * $signed({1'b0, level_sat});
    end
    luma_r_p = 12'({7'd0, src[0]} * {4'd0, rbt_pkg::LUMA_R});
    luma_g_p = 13'({8'd0, src[1]} * {5'd0, rbt_pkg::LUMA_G});
    luma_b_p = 10'({5'd0, src[2]} * {2'd0, rbt_pkg::LUMA_B});
  end

  logic               s1_op_r;
  logic               s1_last_r;
  logic [CW-1:0]      s1_ch_r    [NC];
  logic signed [9:0]  s1_bprod_r [NC];
  logic [11:0]        s1_lr_r;
  logic [12:0]        s1_lg_r;
  logic [9:0]         s1_lb_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_op_r   <= in_ch.op;
      s1_last_r <= in_ch.last_in;
      for (int i = 0; i < NC; i++) begin
        s1_ch_r[i]    <= src[i];
        s1_bprod_r[i] <= bprod[i][9:0];
      end
      s1_lr_r <= luma_r_p;
      s1_lg_r <= luma_g_p;
      s1_lb_r <= luma_b_p;
    end
  end

  // stage 2: finish blend, sum luma
  logic signed [9:0] bstep [NC];
  logic signed [6:0] bsum  [NC];
  logic [CW-1:0]     bres  [NC];
  logic [12:0]       luma_sum;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      bstep[i] = s1_bprod_r[i] >>> 4;
      bsum[i]  = $signed({2'b00, s1_ch_r[i]}) + $signed(bstep[i][6:0]);
      if (bsum[i] < 7'sd0) begin
        bres[i] = '0;
      end else if (bsum[i] > $signed({2'b00, rbt_pkg::CH_MAX})) begin
        bres[i] = rbt_pkg::CH_MAX;
      end else begin
        bres[i] = bsum[i][CW-1:0];
      end
    end
    luma_sum = {1'b0, s1_lr_r} + s1_lg_r + {3'd0, s1_lb_r};
  end

  logic          s2_op_r;
  logic          s2_last_r;
  logic [CW-1:0] s2_blend_r [NC];
  logic [CW-1:0] s2_luma_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_op_r   <= s1_op_r;
      s2_last_r <= s1_last_r;
      for (int i = 0; i < NC; i++) s2_blend_r[i] <= bres[i];
      s2_luma_r <= luma_sum[12:8];
    end
  end

  // stage 3: tone products
  logic [rbt_pkg::TONE_W-1:0] tone  [NC];
  logic [15:0]                tprod [NC];

  always_comb begin
    tone[0] = cfg.red_tone;
    tone[1] = cfg.green_tone;
    tone[2] = cfg.blue_tone;
    for (int i = 0; i < NC; i++) begin
      tprod[i] = {5'd0, tone[i]} * {11'd0, s2_luma_r};
    end
  end

  logic          s3_op_r;
  logic          s3_last_r;
  logic [CW-1:0] s3_blend_r [NC];
  logic [15:0]   s3_tprod_r [NC];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_op_r   <= s2_op_r;
      s3_last_r <= s2_last_r;
      for (int i = 0; i < NC; i++) begin
        s3_blend_r[i] <= s2_blend_r[i];
        s3_tprod_r[i] <= tprod[i];
      end
    end
  end

  // stage 4: saturate, select, output register
  logic [CW-1:0]               tres [NC];
  logic [rbt_pkg::COLOR_W-1:0] color_nxt;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      tres[i] = (|s3_tprod_r[i][15:13]) ? rbt_pkg::CH_MAX : s3_tprod_r[i][12:8];
      color_nxt[i*CW +: CW] = (s3_op_r == rbt_pkg::OP_TINT) ? tres[i] : s3_blend_r[i];
    end
  end

  logic [rbt_pkg::COLOR_W-1:0] color_r;
  logic                        last_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      color_r <= color_nxt;
      last_r  <= s3_last_r;
    end
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.color_out = color_r;
  assign out_ch.last_out  = last_r;

endmodule

// ===== rtl/rbt_checker.sv =====
`timescale 1ns / 1ps

module rbt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rbt_pkg::COLOR_W-1:0] color_out,
  input logic                         last_out
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a free output side never back-pressures the input
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  // a fresh result follows an accepted item that entered the pipeline and passed every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result appeared without matching item");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(color_out) && $stable(last_out))
    else $error("stalled result changed");

endmodule

bind rgb555_blend_and_tint_unit rbt_checker u_rbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .color_out (out_ch.color_out),
  .last_out  (out_ch.last_out)
);
